// ----- hdl/mpmq_pkg.sv -----
// Shared types and constants for the multi-priority message queue.
// No dependencies; every other file of the block imports this package.
package mpmq_pkg;

    localparam int MAIN_DEPTH    = 16;
    localparam int LOW_DEPTH     = 16;
    localparam int PAYLOAD_WIDTH = 32;

    // Stored payload bits: the port carries 32 bits, the lists keep at most that.
    localparam int PL_W    = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
    localparam int MAIN_IW = $clog2(MAIN_DEPTH);
    localparam int LOW_IW  = $clog2(LOW_DEPTH);
    localparam int MAIN_CW = $clog2(MAIN_DEPTH + 1);
    localparam int LOW_CW  = $clog2(LOW_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        LVL_LOW    = 2'd0,
        LVL_NORMAL = 2'd1,
        LVL_HIGH   = 2'd2,
        LVL_URGENT = 2'd3
    } t_level;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [PL_W-1:0] payload;
        t_level          level;
    } t_entry;

endpackage

// ----- hdl/mpmq_cell.sv -----
// One storage slot of a shifting list: holds an entry and hands it to a neighbor.
// Depends on mpmq_pkg for the entry type and the slot operation codes.
module mpmq_cell (
    input  logic              i_clk,
    input  mpmq_pkg::t_cell_op i_op,
    input  mpmq_pkg::t_entry  i_new,
    input  mpmq_pkg::t_entry  i_left,
    input  mpmq_pkg::t_entry  i_right,
    output mpmq_pkg::t_entry  o_entry
);
    import mpmq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        case (i_op)
            CELL_LOAD:       n_entry = i_new;
            CELL_FROM_LEFT:  n_entry = i_left;
            CELL_FROM_RIGHT: n_entry = i_right;
            default:         n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ----- hdl/multi_priority_message_queue.sv -----
// Two-list priority message queue built from rows of shifting slots.
// Depends on mpmq_pkg and mpmq_cell.
//
// Usage: the input channel (i_valid / o_stall) carries one command word:
// push, pop, clear, or no operation, with a level and a payload for pushes.
// Every accepted word produces exactly one result word on the output channel
// (o_valid / i_stall) carrying the popped message, if any, the drop and
// overflow flags, and both list counts after the command.
// o_valid rises in the cycle after a word is accepted. A word can be
// accepted in every cycle while o_stall is low: every slot of the main
// row and the low row loads from its left or right neighbor at once, so
// an insertion or a head removal costs the same at any position.
// The result sits in an output register. While the receiver stalls and that
// register is full, o_stall is raised and no new word is taken; when the
// register drains in the same cycle, the next word is taken without a bubble.
// Reset (synchronous, active low) empties both lists and the output register.
// Slot contents are not cleared; only slots below a count are ever read.
module multi_priority_message_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_level,
    input  logic [31:0] i_payload,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_popped_valid,
    output logic [31:0] o_popped_payload,
    output logic [1:0]  o_popped_level,
    output logic        o_push_dropped,
    output logic        o_push_overflow,
    output logic [4:0]  o_main_count,
    output logic [4:0]  o_low_count
);
    import mpmq_pkg::*;

    // Handshake.
    logic acc;
    logic out_take;

    // Command decode.
    logic is_push;
    logic is_pop;
    logic is_clear;
    logic urgent_q;
    logic main_full;
    logic low_full;
    logic main_ins;
    logic low_ins;
    logic main_rem;
    logic low_rem;
    logic dropped;
    logic overflow;
    logic [MAIN_IW-1:0] ins_pos;

    // List state.
    logic [MAIN_CW-1:0] r_main_used, n_main_used;
    logic [LOW_CW-1:0]  r_low_used, n_low_used;
    t_entry             new_entry;
    t_entry             main_q [MAIN_DEPTH];
    t_entry             low_q [LOW_DEPTH];
    t_cell_op           main_op [MAIN_DEPTH];
    t_cell_op           low_op [LOW_DEPTH];

    // Result register.
    logic               r_out_valid;
    logic               r_popped_valid;
    logic [PL_W-1:0]    r_popped_payload;
    t_level             r_popped_level;
    logic               r_push_dropped;
    logic               r_push_overflow;

    // The output register parts the two channels; input stalls only when it is
    // full and not being drained.
    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = r_out_valid && i_stall;
    assign acc      = i_valid && !o_stall;

    assign is_push  = acc && (i_kind == KIND_PUSH);
    assign is_pop   = acc && (i_kind == KIND_POP);
    assign is_clear = acc && (i_kind == KIND_CLEAR);

    // An urgent entry only ever enters at the front and at most one is queued,
    // so checking the head slot tells whether one is present.
    assign urgent_q  = (r_main_used != '0) && (main_q[0].level == LVL_URGENT);
    assign main_full = (r_main_used == MAIN_CW'(MAIN_DEPTH));
    assign low_full  = (r_low_used == LOW_CW'(LOW_DEPTH));

    assign new_entry = '{payload: PL_W'(i_payload), level: t_level'(i_level)};

    always_comb begin
        dropped  = 1'b0;
        overflow = 1'b0;
        main_ins = 1'b0;
        low_ins  = 1'b0;
        main_rem = 1'b0;
        low_rem  = 1'b0;
        ins_pos  = '0;
        if (is_push) begin
            if (i_level == LVL_LOW) begin
                if (low_full) begin
                    overflow = 1'b1;
                end else begin
                    low_ins = 1'b1;
                end
            end else if ((i_level == LVL_URGENT) && urgent_q) begin
                dropped = 1'b1;
            end else if (main_full) begin
                overflow = 1'b1;
            end else begin
                main_ins = 1'b1;
                // Normal goes to the tail, high goes right behind a queued
                // urgent head or to the front if there is none, urgent goes to the front.
                case (i_level)
                    LVL_NORMAL: ins_pos = r_main_used[MAIN_IW-1:0];
                    LVL_HIGH:   ins_pos = urgent_q ? MAIN_IW'(1) : '0;
                    default:    ins_pos = '0;
                endcase
            end
        end
        if (is_pop) begin
            if (r_main_used != '0) begin
                main_rem = 1'b1;
            end else if (r_low_used != '0) begin
                low_rem = 1'b1;
            end
        end
    end

    always_comb begin
        n_main_used = r_main_used;
        n_low_used  = r_low_used;
        if (is_clear) begin
            n_main_used = '0;
            n_low_used  = '0;
        end else begin
            if (main_ins) begin
                n_main_used = r_main_used + MAIN_CW'(1);
            end else if (main_rem) begin
                n_main_used = r_main_used - MAIN_CW'(1);
            end
            if (low_ins) begin
                n_low_used = r_low_used + LOW_CW'(1);
            end else if (low_rem) begin
                n_low_used = r_low_used - LOW_CW'(1);
            end
        end
    end

    // Main row: slot 0 is the head. An insertion loads the target slot and
    // moves every slot behind it one place back; a pop moves all forward.
    for (genvar gi = 0; gi < MAIN_DEPTH; gi++) begin : g_main
        t_entry left_e;
        t_entry right_e;

        if (gi == 0) begin : g_first
            assign left_e = main_q[gi];
        end else begin : g_inner_l
            assign left_e = main_q[gi-1];
        end
        if (gi == MAIN_DEPTH - 1) begin : g_last
            assign right_e = main_q[gi];
        end else begin : g_inner_r
            assign right_e = main_q[gi+1];
        end

        always_comb begin
            if (main_ins && (MAIN_IW'(gi) == ins_pos)) begin
                main_op[gi] = CELL_LOAD;
            end else if (main_ins && (MAIN_IW'(gi) > ins_pos)) begin
                main_op[gi] = CELL_FROM_LEFT;
            end else if (main_rem) begin
                main_op[gi] = CELL_FROM_RIGHT;
            end else begin
                main_op[gi] = CELL_HOLD;
            end
        end

        mpmq_cell u_slot (
            .i_clk   (i_clk),
            .i_op    (main_op[gi]),
            .i_new   (new_entry),
            .i_left  (left_e),
            .i_right (right_e),
            .o_entry (main_q[gi])
        );
    end

    // Low row: a shifting FIFO. Pushes load the first free slot, pops move
    // every slot one place toward the head.
    for (genvar gj = 0; gj < LOW_DEPTH; gj++) begin : g_low
        t_entry left_e;
        t_entry right_e;

        if (gj == 0) begin : g_first
            assign left_e = low_q[gj];
        end else begin : g_inner_l
            assign left_e = low_q[gj-1];
        end
        if (gj == LOW_DEPTH - 1) begin : g_last
            assign right_e = low_q[gj];
        end else begin : g_inner_r
            assign right_e = low_q[gj+1];
        end

        always_comb begin
            if (low_ins && (LOW_IW'(gj) == r_low_used[LOW_IW-1:0])) begin
                low_op[gj] = CELL_LOAD;
            end else if (low_rem) begin
                low_op[gj] = CELL_FROM_RIGHT;
            end else begin
                low_op[gj] = CELL_HOLD;
            end
        end

        mpmq_cell u_slot (
            .i_clk   (i_clk),
            .i_op    (low_op[gj]),
            .i_new   (new_entry),
            .i_left  (left_e),
            .i_right (right_e),
            .o_entry (low_q[gj])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_used <= '0;
            r_low_used  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_main_used <= n_main_used;
            r_low_used  <= n_low_used;
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_popped_valid  <= main_rem || low_rem;
            r_push_dropped  <= dropped;
            r_push_overflow <= overflow;
            if (main_rem) begin
                r_popped_payload <= main_q[0].payload;
                r_popped_level   <= main_q[0].level;
            end else if (low_rem) begin
                r_popped_payload <= low_q[0].payload;
                r_popped_level   <= LVL_LOW;
            end else begin
                r_popped_payload <= '0;
                r_popped_level   <= LVL_LOW;
            end
        end
    end

    // The counts change only when a word is accepted, which is also when the
    // result register loads, so they always match the word on display.
    assign o_valid          = r_out_valid;
    assign o_popped_valid   = r_popped_valid;
    assign o_popped_payload = 32'(r_popped_payload);
    assign o_popped_level   = r_popped_level;
    assign o_push_dropped   = r_push_dropped;
    assign o_push_overflow  = r_push_overflow;
    assign o_main_count     = 5'(r_main_used);
    assign o_low_count      = 5'(r_low_used);

endmodule

// ----- hdl/mpmq_checker.sv -----
// Port-level checks for the multi-priority message queue, bound to its top.
// Depends on mpmq_pkg for the command codes.
module mpmq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_kind,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_popped_valid,
    input logic [31:0] o_popped_payload,
    input logic [1:0]  o_popped_level,
    input logic        o_push_dropped,
    input logic        o_push_overflow,
    input logic [4:0]  o_main_count,
    input logic [4:0]  o_low_count
);
    import mpmq_pkg::*;

    // A result word stays up while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result word lost while stalled");

    // An accepted clear leaves both lists empty in its result.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_kind == KIND_CLEAR))
        |=> (o_valid && (o_main_count == 5'd0) && (o_low_count == 5'd0)))
        else $error("clear did not empty the lists");

    // A word without a popped message reports zero payload and level.
    a_no_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_popped_valid)
        |-> ((o_popped_payload == 32'd0) && (o_popped_level == 2'd0)))
        else $error("stale pop fields on a word without a message");

    // A pop never reports a push flag at the same time.
    a_pop_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_popped_valid) |-> (!o_push_dropped && !o_push_overflow))
        else $error("pop result carries push flags");

endmodule

bind multi_priority_message_queue mpmq_checker u_mpmq_checker (.*);
